/* design/bpskcr_pkg.sv */
// -----------------------------------------------------------------------------
// BPSK carrier recovery package
// Widths, register indexes, sequencer types and the quarter-wave sine table.
// -----------------------------------------------------------------------------
package bpskcr_pkg;

   localparam int LUT_ADDR_BITS = 10;
   localparam int PHASE_BITS    = 32;

   localparam int QUARTER_BITS = LUT_ADDR_BITS - 2;
   localparam int QUARTER_LEN  = 1 << QUARTER_BITS;

   localparam int SAMPLE_W    = 16;
   localparam int GAIN_W      = 24;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int FRAC_BITS   = 15;

   localparam int OPA_W  = GAIN_W + 1;
   localparam int ERR_W  = SAMPLE_W + 1;
   localparam int OPB_W  = ERR_W;
   localparam int PROD_W = OPA_W + OPB_W;
   localparam int ROT_W  = 2 * SAMPLE_W + 1;
   localparam int SUM_W  = ((PHASE_BITS > PROD_W) ? PHASE_BITS : PROD_W) + 1;

   localparam logic signed [SAMPLE_W-1:0] SINE_PEAK = 16'sd32767;
   localparam logic signed [SAMPLE_W-1:0] SAT_MAX   = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN   = 16'sh8000;

   localparam logic signed [PHASE_BITS-1:0] FREQ_MAX = {1'b0, {(PHASE_BITS-1){1'b1}}};
   localparam logic signed [PHASE_BITS-1:0] FREQ_MIN = {1'b1, {(PHASE_BITS-1){1'b0}}};

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_ALPHA_GAIN = 8'd0;
   localparam csr_index_type CSR_BETA_GAIN  = 8'd1;

   localparam logic [GAIN_W-1:0] ALPHA_RESET = 24'd166886;
   localparam logic [GAIN_W-1:0] BETA_RESET  = 24'd417;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_IC,
      ST_MUL_QS,
      ST_MUL_QC,
      ST_MUL_IS,
      ST_ROT_Q,
      ST_MUL_ERR,
      ST_MUL_BETA,
      ST_MUL_ALPHA,
      ST_COMMIT
   } state_type;

   typedef enum logic [2:0] {
      MUL_SI_C,
      MUL_SQ_S,
      MUL_SQ_C,
      MUL_SI_S,
      MUL_RI_RQ,
      MUL_BETA_ERR,
      MUL_ALPHA_ERR
   } mul_sel_type;

   typedef struct packed {
      logic        accept;
      mul_sel_type mul_sel;
      logic        load_acc;
      logic        load_ri;
      logic        load_rq;
      logic        load_err;
      logic        load_freq;
      logic        commit;
   } ctrl_type;

   typedef logic signed [SAMPLE_W-1:0] qsine_type [QUARTER_LEN];

   localparam real HALF_PI    = 1.5707963267948966;
   localparam real QSINE_STEP = HALF_PI / real'(QUARTER_LEN);

   // round(32767 * sin(pi/2 * k / QUARTER_LEN)), k below QUARTER_LEN
   function automatic qsine_type build_qsine();
      qsine_type t;
      real       x;
      for (int k = 0; k < QUARTER_LEN; k++) begin
         x = 32767.0 * $sin(QSINE_STEP * real'(k));
         t[k] = SAMPLE_W'(int'(x));
      end
      return t;
   endfunction

   localparam qsine_type QSINE = build_qsine();

   // floor shift by FRAC_BITS, then saturate to a sample
   function automatic logic signed [SAMPLE_W-1:0] sat_rot(
      input logic signed [ROT_W-1:0] sum
   );
      logic signed [ROT_W-1:0] sh;
      sh = sum >>> FRAC_BITS;
      if (sh > ROT_W'(SAT_MAX)) begin
         return SAT_MAX;
      end else if (sh < ROT_W'(SAT_MIN)) begin
         return SAT_MIN;
      end
      return sh[SAMPLE_W-1:0];
   endfunction

endpackage

/* design/bpsk_carrier_recovery_loop.sv */
// -----------------------------------------------------------------------------
// BPSK carrier recovery loop
// Second-order Costas loop: derotates each I/Q sample by the current phase
// and updates frequency and phase from the I*Q error.
// -----------------------------------------------------------------------------
// A request is accepted in the idle state; then one 25x17 signed multiplier
// forms seven products in turn (four rotation products, the error product,
// then the integral and proportional gain products). The frequency update is
// registered in ST_MUL_ALPHA, and the result, together with the phase update,
// in ST_COMMIT. req_tready is high again in the cycle in which the result first
// shows, so a new request is taken only once the previous one has committed.
// A result waits in the output register until taken; a following request still
// runs, and it holds in its commit state only while the previous result is
// still waiting. csr_ready is always high.
module bpsk_carrier_recovery_loop
   import bpskcr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,  // [15:0] sample_i, [31:16] sample_q
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,  // [15:0] rotated_i, [31:16] rotated_q
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   ctrl_type ctrl;
   logic     out_free;

   logic [GAIN_W-1:0] alpha_ff, alpha_in;
   logic [GAIN_W-1:0] beta_ff, beta_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic signed [PHASE_BITS-1:0] freq_ff, freq_in;

   logic signed [SAMPLE_W-1:0] si_ff, si_in;
   logic signed [SAMPLE_W-1:0] sq_ff, sq_in;
   logic signed [SAMPLE_W-1:0] s_ff, s_in;
   logic signed [SAMPLE_W-1:0] c_ff, c_in;
   logic signed [ROT_W-1:0]    acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0] ri_ff, ri_in;
   logic signed [SAMPLE_W-1:0] rq_ff, rq_in;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic signed [SAMPLE_W-1:0] out_i_ff, out_i_in;
   logic signed [SAMPLE_W-1:0] out_q_ff, out_q_in;
   logic                       rsp_tvalid_ff, rsp_tvalid_in;

   logic [LUT_ADDR_BITS-1:0]   sin_idx;
   logic [LUT_ADDR_BITS-1:0]   cos_idx;
   logic signed [SAMPLE_W-1:0] sin_val;
   logic signed [SAMPLE_W-1:0] cos_val;

   logic signed [OPA_W-1:0]  op_a;
   logic signed [OPB_W-1:0]  op_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ERR_W-1:0]  err_now;
   logic signed [ROT_W-1:0]  prod_rot;
   logic signed [SUM_W-1:0]  prod_ext;
   logic signed [SUM_W-1:0]  freq_sum;

   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   bpskcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .req_ready (req_tready),
      .ctrl      (ctrl)
   );

   assign sin_idx = phase_ff[PHASE_BITS-1 -: LUT_ADDR_BITS];
   assign cos_idx = sin_idx + LUT_ADDR_BITS'(QUARTER_LEN);

   bpskcr_sine u_sin (
      .idx   (sin_idx),
      .value (sin_val)
   );

   bpskcr_sine u_cos (
      .idx   (cos_idx),
      .value (cos_val)
   );

   assign err_now  = ERR_W'(prod_ff >>> FRAC_BITS);
   assign prod_rot = ROT_W'(prod_ff);
   assign prod_ext = SUM_W'(prod_ff);

   always_comb begin
      case (ctrl.mul_sel)
         MUL_SI_C: begin
            op_a = OPA_W'(si_ff);
            op_b = OPB_W'(c_ff);
         end
         MUL_SQ_S: begin
            op_a = OPA_W'(sq_ff);
            op_b = OPB_W'(s_ff);
         end
         MUL_SQ_C: begin
            op_a = OPA_W'(sq_ff);
            op_b = OPB_W'(c_ff);
         end
         MUL_SI_S: begin
            op_a = OPA_W'(si_ff);
            op_b = OPB_W'(s_ff);
         end
         MUL_RI_RQ: begin
            op_a = OPA_W'(ri_ff);
            op_b = OPB_W'(rq_ff);
         end
         MUL_BETA_ERR: begin
            op_a = signed'({1'b0, beta_ff});
            op_b = err_now;
         end
         MUL_ALPHA_ERR: begin
            op_a = signed'({1'b0, alpha_ff});
            op_b = err_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   bpskcr_mac u_mac (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   always_comb begin
      alpha_in      = alpha_ff;
      beta_in       = beta_ff;
      phase_in      = phase_ff;
      freq_in       = freq_ff;
      si_in         = si_ff;
      sq_in         = sq_ff;
      s_in          = s_ff;
      c_in          = c_ff;
      acc_in        = acc_ff;
      ri_in         = ri_ff;
      rq_in         = rq_ff;
      err_in        = err_ff;
      out_i_in      = out_i_ff;
      out_q_in      = out_q_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      freq_sum      = SUM_W'(freq_ff) + prod_ext;

      if (csr_valid) begin
         case (csr_index)
            CSR_ALPHA_GAIN: alpha_in = csr_data[GAIN_W-1:0];
            CSR_BETA_GAIN:  beta_in  = csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end

      if (ctrl.accept) begin
         si_in = signed'(req_tdata[SAMPLE_W-1:0]);
         sq_in = signed'(req_tdata[2*SAMPLE_W-1:SAMPLE_W]);
         s_in  = sin_val;
         c_in  = cos_val;
      end
      if (ctrl.load_acc) begin
         acc_in = prod_rot;
      end
      if (ctrl.load_ri) begin
         ri_in = sat_rot(acc_ff + prod_rot);
      end
      if (ctrl.load_rq) begin
         rq_in = sat_rot(acc_ff - prod_rot);
      end
      if (ctrl.load_err) begin
         err_in = err_now;
      end
      if (ctrl.load_freq) begin
         if (freq_sum > SUM_W'(FREQ_MAX)) begin
            freq_in = FREQ_MAX;
         end else if (freq_sum < SUM_W'(FREQ_MIN)) begin
            freq_in = FREQ_MIN;
         end else begin
            freq_in = freq_sum[PHASE_BITS-1:0];
         end
      end
      if (ctrl.commit) begin
         phase_in      = phase_ff + unsigned'(freq_ff) + prod_ext[PHASE_BITS-1:0];
         out_i_in      = ri_ff;
         out_q_in      = rq_ff;
         rsp_tvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff      <= ALPHA_RESET;
         beta_ff       <= BETA_RESET;
         phase_ff      <= '0;
         freq_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         alpha_ff      <= alpha_in;
         beta_ff       <= beta_in;
         phase_ff      <= phase_in;
         freq_ff       <= freq_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff    <= si_in;
      sq_ff    <= sq_in;
      s_ff     <= s_in;
      c_ff     <= c_in;
      acc_ff   <= acc_in;
      ri_ff    <= ri_in;
      rq_ff    <= rq_in;
      err_ff   <= err_in;
      out_i_ff <= out_i_in;
      out_q_ff <= out_q_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {out_q_ff, out_i_ff};

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in progress");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && rsp_tvalid && !$past(rsp_tvalid)) |-> $past(ctrl.commit))
      else $error("result raised without a commit");

   a_phase_on_commit: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && phase_ff != $past(phase_ff)) |-> $past(ctrl.commit))
      else $error("phase changed outside a commit");

   a_freq_on_update: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && freq_ff != $past(freq_ff)) |-> $past(ctrl.load_freq))
      else $error("frequency changed outside its update");

endmodule

/* design/bpskcr_sine.sv */
// -----------------------------------------------------------------------------
// BPSK carrier recovery sine lookup
// Full-wave sine from the quarter-wave table by quadrant folding.
// -----------------------------------------------------------------------------
module bpskcr_sine
   import bpskcr_pkg::*;
(
   input  logic [LUT_ADDR_BITS-1:0] idx,
   output logic signed [SAMPLE_W-1:0] value
);

   logic [1:0]              quad;
   logic [QUARTER_BITS-1:0] r;
   logic [QUARTER_BITS-1:0] r_mirror;
   logic signed [SAMPLE_W-1:0] mag;

   always_comb begin
      quad     = idx[LUT_ADDR_BITS-1 -: 2];
      r        = idx[QUARTER_BITS-1:0];
      r_mirror = QUARTER_BITS'(0) - r;
      if (quad[0]) begin
         mag = (r == '0) ? SINE_PEAK : QSINE[r_mirror];
      end else begin
         mag = QSINE[r];
      end
      value = quad[1] ? -mag : mag;
   end

endmodule

/* design/bpskcr_mac.sv */
// -----------------------------------------------------------------------------
// BPSK carrier recovery multiplier
// Shared signed multiplier with registered product.
// -----------------------------------------------------------------------------
module bpskcr_mac
   import bpskcr_pkg::*;
(
   input  logic                     clock,
   input  logic signed [OPA_W-1:0]  op_a,
   input  logic signed [OPB_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

/* design/bpskcr_ctrl.sv */
// -----------------------------------------------------------------------------
// BPSK carrier recovery sequencer
// Steps one request through the shared multiplier and the loop update.
// -----------------------------------------------------------------------------
module bpskcr_ctrl
   import bpskcr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     out_free,
   output logic     req_ready,
   output ctrl_type ctrl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      ctrl           = '0;
      ctrl.mul_sel   = MUL_ALPHA_ERR;
      req_ready      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            ctrl.accept = req_valid;
            if (req_valid) begin
               state_in = ST_MUL_IC;
            end
         end
         ST_MUL_IC: begin
            ctrl.mul_sel = MUL_SI_C;
            state_in     = ST_MUL_QS;
         end
         ST_MUL_QS: begin
            ctrl.mul_sel  = MUL_SQ_S;
            ctrl.load_acc = 1'b1;
            state_in      = ST_MUL_QC;
         end
         ST_MUL_QC: begin
            ctrl.mul_sel = MUL_SQ_C;
            ctrl.load_ri = 1'b1;
            state_in     = ST_MUL_IS;
         end
         ST_MUL_IS: begin
            ctrl.mul_sel  = MUL_SI_S;
            ctrl.load_acc = 1'b1;
            state_in      = ST_ROT_Q;
         end
         ST_ROT_Q: begin
            ctrl.mul_sel = MUL_RI_RQ;
            ctrl.load_rq = 1'b1;
            state_in     = ST_MUL_ERR;
         end
         ST_MUL_ERR: begin
            ctrl.mul_sel = MUL_RI_RQ;
            state_in     = ST_MUL_BETA;
         end
         ST_MUL_BETA: begin
            ctrl.mul_sel  = MUL_BETA_ERR;
            ctrl.load_err = 1'b1;
            state_in      = ST_MUL_ALPHA;
         end
         ST_MUL_ALPHA: begin
            ctrl.mul_sel   = MUL_ALPHA_ERR;
            ctrl.load_freq = 1'b1;
            state_in       = ST_COMMIT;
         end
         ST_COMMIT: begin
            ctrl.mul_sel = MUL_ALPHA_ERR;
            if (out_free) begin
               ctrl.commit = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
